// ===== rtl/ptpw_pkg.sv =====
// Shared types and constants for the point target peak width block.
// Used by ptpw_ctrl, ptpw_dp and point_target_peak_width; no dependencies.
package ptpw_pkg;

  // Configuration register map
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned SideCfgW = 8;
  localparam int unsigned DropW    = 15;

  localparam logic [CfgIdxW-1:0] REG_IMG_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_IMG_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DROP       = 2'd2;

  localparam logic [SideCfgW-1:0] IMG_WIDTH_RST  = 8'd128;
  localparam logic [SideCfgW-1:0] IMG_HEIGHT_RST = 8'd128;
  localparam logic [DropW-1:0]    DROP_RST       = 15'd768;  // 3 dB in Q8.8

  // Walk direction away from the peak
  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;        // store pixel, track peak, advance position
    logic restart;     // clear load position and peak tracking
    logic walk_start;  // put walk index and address on the peak
    logic walk_read;   // read store at walk address
    logic walk_step;   // move one pixel further along dir
    logic walk_stop;   // record walk index as stop index for dir
    logic emit;        // register result, pulse strobe
    dir_e dir;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic last_pixel;  // load position is the last pixel of the image
    logic walk_out;    // walk index is past an image edge
    logic walk_pass;   // read pixel is strictly above the threshold
  } sts_t;

endpackage

// ===== rtl/point_target_peak_width.sv =====
// Top level of the point target peak width block.
// Instantiates ptpw_ctrl and ptpw_dp; depends on ptpw_pkg.
//
//   channel   ports                                   beat marked by
//   --------  --------------------------------------  --------------------
//   config    cfg_we_i, cfg_idx_i, cfg_data_i         cfg_we_i high
//   pixel in  pixel_db_i                              start high, busy low
//   result    peak_col_o, peak_row_o, peak_level_o,   done_o high, 1 cycle
//             range_width_o, azimuth_width_o
//
// Pixels load at one beat per cycle in raster order; busy stays low while
// loading. On the last pixel busy rises and four walks (left, right, up,
// down) run over the single-port image store: each walk opens with a setup
// state, and each pixel it visits is read in a check state and compared in
// an evaluate state, since each read is registered before its compare; an
// emit state follows the last walk. done_o pulses in the first cycle with
// busy low again, taking the receiver's beat unconditionally.
// A config write to a mapped register restarts the image load. The store is not cleared at reset.
module point_target_peak_width #(
  parameter int unsigned MAX_SIDE   = 128,
  parameter int unsigned PIXEL_BITS = 16,
  localparam int unsigned CoordW    = $clog2(MAX_SIDE),
  localparam int unsigned WidthW    = $clog2(MAX_SIDE + 2)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config
  input  logic                          cfg_we_i,
  input  logic [ptpw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ptpw_pkg::CfgDataW-1:0] cfg_data_i,
  // pixel input
  input  logic                          start,
  output logic                          busy,
  input  logic signed [PIXEL_BITS-1:0]  pixel_db_i,
  // result
  output logic                          done_o,
  output logic [CoordW-1:0]             peak_col_o,
  output logic [CoordW-1:0]             peak_row_o,
  output logic signed [PIXEL_BITS-1:0]  peak_level_o,
  output logic [WidthW-1:0]             range_width_o,
  output logic [WidthW-1:0]             azimuth_width_o
);

  ptpw_pkg::cmd_t cmd;
  ptpw_pkg::sts_t sts;

  ptpw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  ptpw_dp #(
    .MAX_SIDE   (MAX_SIDE),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .pixel_db_i      (pixel_db_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .done_o          (done_o),
    .peak_col_o      (peak_col_o),
    .peak_row_o      (peak_row_o),
    .peak_level_o    (peak_level_o),
    .range_width_o   (range_width_o),
    .azimuth_width_o (azimuth_width_o)
  );

endmodule

// ===== rtl/ptpw_ctrl.sv =====
// Sequencer for loading and the four width walks of the peak width block.
// Depends on ptpw_pkg.
module ptpw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  ptpw_pkg::sts_t  sts_i,
  output ptpw_pkg::cmd_t  cmd_o,
  output logic            busy
);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]     state_q, state_d;
  ptpw_pkg::dir_e dir_q, dir_d;
  logic           walk_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      dir_q   <= ptpw_pkg::DIR_LEFT;
    end else begin
      state_q <= state_d;
      dir_q   <= dir_d;
    end
  end

  // load, walk and emit sequencing; after a walk stops: next direction, or emit after the last one
  always_comb begin
    walk_done = 1'b0;
    state_d   = state_q;
    dir_d     = dir_q;
    cmd_o     = '0;
    cmd_o.dir = dir_q;
    unique case (state_q)
      ST_LOAD: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (sts_i.last_pixel) begin
            state_d = ST_INIT;
            dir_d   = ptpw_pkg::DIR_LEFT;
          end
        end
      end
      ST_INIT: begin
        cmd_o.walk_start = 1'b1;
        state_d          = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.walk_out) begin
          cmd_o.walk_stop = 1'b1;
          walk_done       = 1'b1;
        end else begin
          cmd_o.walk_read = 1'b1;
          state_d         = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts_i.walk_pass) begin
          cmd_o.walk_step = 1'b1;
          state_d         = ST_CHECK;
        end else begin
          cmd_o.walk_stop = 1'b1;
          walk_done       = 1'b1;
        end
      end
      ST_EMIT: begin
        cmd_o.emit    = 1'b1;
        cmd_o.restart = 1'b1;
        state_d       = ST_LOAD;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    if (walk_done) begin
      unique case (dir_q)
        ptpw_pkg::DIR_LEFT:  begin dir_d = ptpw_pkg::DIR_RIGHT; state_d = ST_INIT; end
        ptpw_pkg::DIR_RIGHT: begin dir_d = ptpw_pkg::DIR_UP;    state_d = ST_INIT; end
        ptpw_pkg::DIR_UP:    begin dir_d = ptpw_pkg::DIR_DOWN;  state_d = ST_INIT; end
        ptpw_pkg::DIR_DOWN:  begin dir_d = ptpw_pkg::DIR_LEFT;  state_d = ST_EMIT; end
        default:             begin dir_d = ptpw_pkg::DIR_LEFT;  state_d = ST_EMIT; end
      endcase
    end
  end

  assign busy = (state_q != ST_LOAD);

endmodule

// ===== rtl/ptpw_dp.sv =====
// Datapath of the peak width block: config registers, image store, peak
// tracking, walk index/address and result registers. Depends on ptpw_pkg.
module ptpw_dp #(
  parameter int unsigned MAX_SIDE   = 128,
  parameter int unsigned PIXEL_BITS = 16,
  localparam int unsigned CoordW    = $clog2(MAX_SIDE),
  localparam int unsigned WidthW    = $clog2(MAX_SIDE + 2)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ptpw_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [ptpw_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic signed [PIXEL_BITS-1:0]        pixel_db_i,
  input  ptpw_pkg::cmd_t                      cmd_i,
  output ptpw_pkg::sts_t                      sts_o,
  output logic                                done_o,
  output logic [CoordW-1:0]                   peak_col_o,
  output logic [CoordW-1:0]                   peak_row_o,
  output logic signed [PIXEL_BITS-1:0]        peak_level_o,
  output logic [WidthW-1:0]                   range_width_o,
  output logic [WidthW-1:0]                   azimuth_width_o
);

  localparam int unsigned SideW = $clog2(MAX_SIDE + 1);
  localparam int unsigned Depth = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned ThrW  = ((PIXEL_BITS > 16) ? PIXEL_BITS : 16) + 1;

  function automatic logic [SideW-1:0] eff_side(input logic [ptpw_pkg::SideCfgW-1:0] v);
    logic [SideW-1:0] r;
    if (v == '0) begin
      r = SideW'(1);
    end else if (32'(v) > MAX_SIDE) begin
      r = SideW'(MAX_SIDE);
    end else begin
      r = SideW'(v);
    end
    return r;
  endfunction

  // config
  logic [ptpw_pkg::SideCfgW-1:0] img_width_q, img_height_q;
  logic [ptpw_pkg::DropW-1:0]    drop_q;
  logic                          cfg_hit;

  // load and peak tracking
  logic [CoordW-1:0]             load_col_q, load_row_q;
  logic [AddrW-1:0]              load_addr_q;
  logic signed [PIXEL_BITS-1:0]  best_level_q;
  logic [CoordW-1:0]             best_col_q, best_row_q;
  logic [AddrW-1:0]              best_addr_q;

  // walks
  logic signed [SideW:0]         idx_q;
  logic [AddrW-1:0]              waddr_q;
  logic signed [PIXEL_BITS-1:0]  rd_data_q;
  logic signed [SideW:0]         left_q, right_q, up_q, down_q;
  logic                          walk_out;

  // results
  logic                          done_q;
  logic [CoordW-1:0]             peak_col_q, peak_row_q;
  logic signed [PIXEL_BITS-1:0]  peak_level_q;
  logic [WidthW-1:0]             range_width_q, azimuth_width_q;

  logic [SideW-1:0]              w_eff, h_eff;
  logic                          col_last, row_last, restart;
  logic signed [ThrW-1:0]        thr;
  logic signed [SideW:0]         rw_diff, aw_diff;

  logic signed [PIXEL_BITS-1:0]  mem [Depth];

  assign w_eff   = eff_side(img_width_q);
  assign h_eff   = eff_side(img_height_q);
  assign cfg_hit = cfg_we_i && ((cfg_idx_i == ptpw_pkg::REG_IMG_WIDTH) ||
                                (cfg_idx_i == ptpw_pkg::REG_IMG_HEIGHT) ||
                                (cfg_idx_i == ptpw_pkg::REG_DROP));
  assign restart = cmd_i.restart || cfg_hit;

  assign col_last = (SideW'(load_col_q) == w_eff - SideW'(1));
  assign row_last = (SideW'(load_row_q) == h_eff - SideW'(1));

  // walk continues while pixel > peak - drop
  assign thr = ThrW'(best_level_q) - signed'(ThrW'(drop_q));

  assign sts_o.last_pixel = col_last && row_last;
  assign sts_o.walk_pass  = ThrW'(rd_data_q) > thr;
  assign sts_o.walk_out   = walk_out;
  always_comb begin
    unique case (cmd_i.dir)
      ptpw_pkg::DIR_LEFT,
      ptpw_pkg::DIR_UP:    walk_out = idx_q[SideW];
      ptpw_pkg::DIR_RIGHT: walk_out = (idx_q == signed'({1'b0, w_eff}));
      ptpw_pkg::DIR_DOWN:  walk_out = (idx_q == signed'({1'b0, h_eff}));
      default:             walk_out = 1'b1;
    endcase
  end

  assign rw_diff = right_q - left_q;
  assign aw_diff = down_q - up_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q  <= ptpw_pkg::IMG_WIDTH_RST;
      img_height_q <= ptpw_pkg::IMG_HEIGHT_RST;
      drop_q       <= ptpw_pkg::DROP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ptpw_pkg::REG_IMG_WIDTH:  img_width_q  <= cfg_data_i[ptpw_pkg::SideCfgW-1:0];
        ptpw_pkg::REG_IMG_HEIGHT: img_height_q <= cfg_data_i[ptpw_pkg::SideCfgW-1:0];
        ptpw_pkg::REG_DROP:       drop_q       <= cfg_data_i[ptpw_pkg::DropW-1:0];
        default: ;
      endcase
    end
  end

  // load position and peak tracking (first max in raster order wins)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_col_q   <= '0;
      load_row_q   <= '0;
      load_addr_q  <= '0;
      best_level_q <= {1'b1, {(PIXEL_BITS-1){1'b0}}};
      best_col_q   <= '0;
      best_row_q   <= '0;
      best_addr_q  <= '0;
    end else if (restart) begin
      load_col_q   <= '0;
      load_row_q   <= '0;
      load_addr_q  <= '0;
      best_level_q <= {1'b1, {(PIXEL_BITS-1){1'b0}}};
      best_col_q   <= '0;
      best_row_q   <= '0;
      best_addr_q  <= '0;
    end else if (cmd_i.load) begin
      if (pixel_db_i > best_level_q) begin
        best_level_q <= pixel_db_i;
        best_col_q   <= load_col_q;
        best_row_q   <= load_row_q;
        best_addr_q  <= load_addr_q;
      end
      if (col_last) begin
        load_col_q <= '0;
        load_row_q <= row_last ? '0 : load_row_q + CoordW'(1);
      end else begin
        load_col_q <= load_col_q + CoordW'(1);
      end
      load_addr_q <= (col_last && row_last) ? '0 : load_addr_q + AddrW'(1);
    end
  end

  // image store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem[load_addr_q] <= pixel_db_i;
    end
    if (cmd_i.walk_read) begin
      rd_data_q <= mem[waddr_q];
    end
  end

  // walk index and address; address wraps harmlessly once index leaves the image
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_start) begin
      unique case (cmd_i.dir)
        ptpw_pkg::DIR_LEFT,
        ptpw_pkg::DIR_RIGHT: idx_q <= signed'((SideW+1)'(best_col_q));
        default:             idx_q <= signed'((SideW+1)'(best_row_q));
      endcase
      waddr_q <= best_addr_q;
    end else if (cmd_i.walk_step) begin
      unique case (cmd_i.dir)
        ptpw_pkg::DIR_LEFT: begin
          idx_q   <= idx_q - (SideW+1)'(1);
          waddr_q <= waddr_q - AddrW'(1);
        end
        ptpw_pkg::DIR_RIGHT: begin
          idx_q   <= idx_q + (SideW+1)'(1);
          waddr_q <= waddr_q + AddrW'(1);
        end
        ptpw_pkg::DIR_UP: begin
          idx_q   <= idx_q - (SideW+1)'(1);
          waddr_q <= waddr_q - AddrW'(w_eff);
        end
        default: begin
          idx_q   <= idx_q + (SideW+1)'(1);
          waddr_q <= waddr_q + AddrW'(w_eff);
        end
      endcase
    end
    if (cmd_i.walk_stop) begin
      unique case (cmd_i.dir)
        ptpw_pkg::DIR_LEFT:  left_q  <= idx_q;
        ptpw_pkg::DIR_RIGHT: right_q <= idx_q;
        ptpw_pkg::DIR_UP:    up_q    <= idx_q;
        default:             down_q  <= idx_q;
      endcase
    end
  end

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      peak_col_q      <= best_col_q;
      peak_row_q      <= best_row_q;
      peak_level_q    <= best_level_q;
      range_width_q   <= rw_diff[WidthW-1:0];
      azimuth_width_q <= aw_diff[WidthW-1:0];
    end
  end

  assign done_o          = done_q;
  assign peak_col_o      = peak_col_q;
  assign peak_row_o      = peak_row_q;
  assign peak_level_o    = peak_level_q;
  assign range_width_o   = range_width_q;
  assign azimuth_width_o = azimuth_width_q;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for point_target_peak_width: random dB images in, peak and widths out.
// A tracker class keeps its own image copy and predicts each result.
// Depends on ptpw_pkg and the point_target_peak_width RTL.
module tb_top;

  localparam int MAX_SIDE   = 128;
  localparam int MAX_PIX    = MAX_SIDE * MAX_SIDE;
  localparam int IDLE_LIMIT = 4000;  // cycles with no beat on any channel
  localparam int TAIL_WAIT  = 600;
  localparam int ITEM_GOAL  = 600;

  // Index 3 is not mapped; a write to it must leave the load untouched.
  localparam logic [ptpw_pkg::CfgIdxW-1:0] REG_UNMAPPED = 2'd3;

  // One measured point target
  typedef struct packed {
    logic [6:0]         col;
    logic [6:0]         row;
    logic signed [15:0] level;
    logic [7:0]         rng;
    logic [7:0]         azi;
  } peak_t;

  // Tracks the image as it loads and measures the widths at the programmed drop on its last pixel.
  class peak_width_tracker;
    logic signed [15:0] image_copy [0:MAX_PIX-1];
    logic [7:0]         width_reg;
    logic [7:0]         height_reg;
    logic [14:0]        drop_reg;
    logic signed [15:0] best_lvl;
    int                 best_c;
    int                 best_r;
    int                 cur_c;
    int                 cur_r;
    peak_t              pending[$];
    int unsigned        errors;

    function new();
      width_reg  = ptpw_pkg::IMG_WIDTH_RST;
      height_reg = ptpw_pkg::IMG_HEIGHT_RST;
      drop_reg   = ptpw_pkg::DROP_RST;
      errors     = 0;
      clear_load();
    endfunction

    function void clear_load();
      best_lvl = 16'sh8000;
      best_c   = 0;
      best_r   = 0;
      cur_c    = 0;
      cur_r    = 0;
    endfunction

    // 0 reads as 1, anything past the store side reads as the store side
    function int side_of(logic [7:0] v);
      if (v == 0) return 1;
      if (v > MAX_SIDE) return MAX_SIDE;
      return int'(v);
    endfunction

    function void apply_reg(logic [ptpw_pkg::CfgIdxW-1:0] idx,
                            logic [ptpw_pkg::CfgDataW-1:0] data);
      case (idx)
        ptpw_pkg::REG_IMG_WIDTH:  width_reg  = data[7:0];
        ptpw_pkg::REG_IMG_HEIGHT: height_reg = data[7:0];
        ptpw_pkg::REG_DROP:       drop_reg   = data[ptpw_pkg::DropW-1:0];
        default:                  return;
      endcase
      clear_load();
    endfunction

    function peak_t measure(int w, int h);
      peak_t p;
      int    thr;
      int    lo;
      int    hi;
      thr = int'(best_lvl) - int'(drop_reg);
      lo = best_c;
      while (lo >= 0 && int'(image_copy[best_r * w + lo]) > thr) lo--;
      hi = best_c;
      while (hi < w && int'(image_copy[best_r * w + hi]) > thr) hi++;
      p.rng = 8'(hi - lo);
      lo = best_r;
      while (lo >= 0 && int'(image_copy[lo * w + best_c]) > thr) lo--;
      hi = best_r;
      while (hi < h && int'(image_copy[hi * w + best_c]) > thr) hi++;
      p.azi   = 8'(hi - lo);
      p.col   = 7'(best_c);
      p.row   = 7'(best_r);
      p.level = best_lvl;
      return p;
    endfunction

    function void note_pixel(logic signed [15:0] px);
      int w;
      int h;
      w = side_of(width_reg);
      h = side_of(height_reg);
      if (cur_c >= w) cur_c = 0;
      if (cur_r >= h) cur_r = 0;
      image_copy[cur_r * w + cur_c] = px;
      // strict compare keeps the first peak on ties
      if (px > best_lvl) begin
        best_lvl = px;
        best_c   = cur_c;
        best_r   = cur_r;
      end
      if (cur_c + 1 < w) begin
        cur_c++;
        return;
      end
      cur_c = 0;
      if (cur_r + 1 < h) begin
        cur_r++;
        return;
      end
      pending.push_back(measure(w, h));
      clear_load();
    endfunction

    function void check_field(string what, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t ERROR %s: expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    function void check_peak(peak_t got);
      peak_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t ERROR result beat with no image pending: col %0d row %0d", $time,
                 got.col, got.row);
        return;
      end
      want = pending.pop_front();
      check_field("peak_col", int'(want.col), int'(got.col));
      check_field("peak_row", int'(want.row), int'(got.row));
      check_field("peak_level", int'(want.level), int'(got.level));
      check_field("range_width", int'(want.rng), int'(got.rng));
      check_field("azimuth_width", int'(want.azi), int'(got.azi));
    endfunction
  endclass

  // DUT ports
  logic                          clk_i      = 1'b0;
  logic                          rst_ni     = 1'b0;
  logic                          cfg_we_i   = 1'b0;
  logic [ptpw_pkg::CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [ptpw_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                          start      = 1'b0;
  logic                          busy;
  logic signed [15:0]            pixel_db_i = '0;
  logic                          done_o;
  logic [6:0]                    peak_col_o;
  logic [6:0]                    peak_row_o;
  logic signed [15:0]            peak_level_o;
  logic [7:0]                    range_width_o;
  logic [7:0]                    azimuth_width_o;

  peak_width_tracker board;
  int unsigned       pixels_sent = 0;
  int unsigned       idle_cycles = 0;
  bit                steady      = 1'b0;  // phase with no sender gaps

  point_target_peak_width dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Monitor and watchdog. Everything is sampled at the rising edge; the bench
  // only changes inputs at the falling edge, so there is no race here.
  // The result check runs before the pixel note: a result beat and the first
  // pixel of the next image can share an edge.
  always @(posedge clk_i) begin
    peak_t seen;
    if (rst_ni) begin
      if (cfg_we_i) board.apply_reg(cfg_idx_i, cfg_data_i);
      if (done_o) begin
        seen.col   = peak_col_o;
        seen.row   = peak_row_o;
        seen.level = peak_level_o;
        seen.rng   = range_width_o;
        seen.azi   = azimuth_width_o;
        board.check_peak(seen);
      end
      if (start && !busy) board.note_pixel(pixel_db_i);
    end
    if (cfg_we_i || done_o || (start && !busy)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t watchdog: no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // Mostly back-to-back, some short gaps, a rare long one
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // One pixel beat. start is held high across back-to-back beats and only
  // dropped for a gap, so it never toggles twice in one step.
  task automatic send_pixel(input logic signed [15:0] px);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start      <= 1'b1;
    pixel_db_i <= px;
    do @(posedge clk_i); while (busy);
    pixels_sent++;
  endtask

  // Sender pause: drop start and wait for every pending result
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [ptpw_pkg::CfgIdxW-1:0] idx,
                           input logic [ptpw_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Side registers are 8 bits; junk in the upper data bits must be ignored
  task automatic write_side(input logic [ptpw_pkg::CfgIdxW-1:0] idx, input int v);
    logic [ptpw_pkg::CfgDataW-1:0] data;
    data = {7'($urandom_range(0, 127)), 8'(v)};
    if ($urandom_range(0, 1) == 0) data[14:8] = '0;
    write_reg(idx, data);
  endtask

  // Random image, first count pixels in raster order. Three flavors:
  // full-range noise, a point target falling off quadratically, and a
  // coarse level set with many ties.
  task automatic send_image(input int w, input int h, input int count);
    int mode;
    int pc;
    int pr;
    int top;
    int scale;
    int v;
    int n;
    mode  = $urandom_range(0, 2);
    pc    = $urandom_range(0, w - 1);
    pr    = $urandom_range(0, h - 1);
    top   = int'($urandom_range(0, 65535)) - 32768;
    scale = $urandom_range(0, 2000);
    n     = 0;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if (n >= count) return;
        case (mode)
          0: v = $urandom_range(0, 65535);
          1: begin
            v = top - ((c - pc) * (c - pc) + (r - pr) * (r - pr)) * scale
                - int'($urandom_range(0, 63));
            if (v < -32768) v = -32768;
          end
          default: v = int'($urandom_range(0, 3)) * 256 - 512;
        endcase
        send_pixel(16'(v));
        n++;
      end
    end
  endtask

  task automatic send_list(input logic signed [15:0] vals[$]);
    foreach (vals[i]) send_pixel(vals[i]);
  endtask

  // Extreme side value for one axis of a phase
  function automatic int extreme_side();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 1;
      2: return 128;
      3: return 129;
      default: return 255;
    endcase
  endfunction

  initial begin
    int w_cfg;
    int h_cfg;
    int w;
    int h;
    int drop;
    int n_img;
    int cut;
    board = new();

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed ----
    // A few pixels at the reset size (128x128), then a register write must
    // throw the partial load away.
    send_list('{16'sh8000, 16'sh7FFF, 16'sh0000});
    settle();
    write_side(ptpw_pkg::REG_IMG_WIDTH, 3);
    write_side(ptpw_pkg::REG_IMG_HEIGHT, 3);
    write_reg(ptpw_pkg::REG_DROP, 15'd768);

    // Two equal maxima: the first in raster order is the peak
    send_list('{16'sh8000, 16'sh0000, 16'sh8000,
                16'sd1000, 16'sh7FFF, 16'sd32000,
                16'sh8000, 16'sh7FFF, 16'sh8000});
    // Every pixel at the most negative level: peak at the origin, walks run
    // off every edge
    send_list('{16'sh8000, 16'sh8000, 16'sh8000,
                16'sh8000, 16'sh8000, 16'sh8000,
                16'sh8000, 16'sh8000, 16'sh8000});
    settle();

    // Zero drop: the peak fails its own compare, both widths are zero
    write_side(ptpw_pkg::REG_IMG_WIDTH, 2);
    write_side(ptpw_pkg::REG_IMG_HEIGHT, 2);
    write_reg(ptpw_pkg::REG_DROP, 15'd0);
    send_list('{16'sd5, 16'sh7FFF, 16'sh8000, 16'sd256});
    settle();

    // Largest drop; a write to the unmapped index mid-image must not restart
    write_reg(ptpw_pkg::REG_DROP, 15'h7FFF);
    send_list('{16'sh5555, 16'shAAAA});
    settle();
    write_reg(REG_UNMAPPED, 15'h7FFF);
    send_list('{16'sh00FF, 16'shFF00});
    settle();

    // ---- random phases ----
    // Each phase waits for every result, then reprograms all registers.
    // Most images are small; now and then one axis goes to an extreme while
    // the other stays at one or two pixels so the image stays short.
    while (pixels_sent < ITEM_GOAL) begin
      settle();
      case ($urandom_range(0, 9))
        0: begin
          w_cfg = extreme_side();
          h_cfg = $urandom_range(1, 2);
        end
        1: begin
          w_cfg = $urandom_range(1, 2);
          h_cfg = extreme_side();
        end
        default: begin
          w_cfg = $urandom_range(0, 8);
          h_cfg = $urandom_range(0, 8);
        end
      endcase
      case ($urandom_range(0, 5))
        0: drop = 0;
        1: drop = 32767;
        2: drop = 768;
        3: drop = $urandom_range(1, 2000);
        default: drop = $urandom_range(0, 32767);
      endcase
      write_side(ptpw_pkg::REG_IMG_WIDTH, w_cfg);
      write_side(ptpw_pkg::REG_IMG_HEIGHT, h_cfg);
      write_reg(ptpw_pkg::REG_DROP, 15'(drop));
      w = board.side_of(8'(w_cfg));
      h = board.side_of(8'(h_cfg));
      steady = ($urandom_range(0, 3) == 0);
      n_img = (w * h > 64) ? 1 : $urandom_range(1, 4);
      for (int k = 0; k < n_img; k++) begin
        // Occasionally abandon an image partway: rewrite the drop register
        // (same value) so the load restarts, then send the image whole.
        if (w * h > 1 && $urandom_range(0, 15) == 0) begin
          cut = $urandom_range(1, w * h - 1);
          send_image(w, h, cut);
          settle();
          write_reg(ptpw_pkg::REG_DROP, 15'(drop));
        end
        send_image(w, h, w * h);
      end
    end

    // ---- drain ----
    @(negedge clk_i);
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
